// ----- rtl/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define TISP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define TISP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TISP_ASSERT(lbl, clk, rstn, prop, msg)
`define TISP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/tisp_pkg.sv -----
`timescale 1ns / 1ps

package tisp_pkg;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

  typedef struct packed {
    logic child_re;
    logic child_we;
    logic mark_re;
    logic mark_we;
  } tisp_mem_req_t;

endpackage

// ----- rtl/tisp_store.sv -----
`timescale 1ns / 1ps

module tisp_store
  import tisp_pkg::*;
#(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  tisp_mem_req_t                                 req,
  input  logic [$clog2(MAX_NODES*ALPHABET_SIZE)-1:0]    child_raddr,
  input  logic [$clog2(MAX_NODES*ALPHABET_SIZE)-1:0]    child_waddr,
  input  logic [$clog2(MAX_NODES)-1:0]                  child_wdata,
  input  logic [$clog2(MAX_NODES)-1:0]                  mark_addr,
  output logic [$clog2(MAX_NODES)-1:0]                  child_q,
  output logic                                          mark_q,
  output logic                                          ready
);

  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int ADDR_W      = $clog2(CHILD_DEPTH);

  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
  logic              mark_mem  [MAX_NODES];

  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clearing_r;
  logic [NODE_W-1:0] child_q_r;
  logic              mark_q_r;
  logic              clr_mark;

  // sweep both tables once after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      if (clr_cnt_r == ADDR_W'(CHILD_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign clr_mark = clearing_r && (clr_cnt_r < ADDR_W'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      child_mem[clr_cnt_r] <= '0;
    end else if (req.child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (req.child_re) begin
      child_q_r <= child_mem[child_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_mark) begin
      mark_mem[clr_cnt_r[NODE_W-1:0]] <= 1'b0;
    end else if (req.mark_we) begin
      mark_mem[mark_addr] <= 1'b1;
    end
    if (req.mark_re) begin
      mark_q_r <= mark_mem[mark_addr];
    end
  end

  assign child_q = child_q_r;
  assign mark_q  = mark_q_r;
  assign ready   = !clearing_r;

endmodule

// ----- rtl/trie_insert_search_prefix.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// letter-serial trie over a fixed node pool, root is node 0
// request channel: in_command, in_letter, in_last_letter, taken on a clock
//   edge with start high and busy low; one request per letter of a word
// result channel: out_found and out_pool_full, shown for one cycle with
//   out_valid high; only the last letter of a word gives a result, and the
//   receiver cannot stall it
// each letter is one synchronous read of the current node's child entry,
//   then the step and any write back of a new child
// the last letter of a search adds a step that reads the end mark of the
//   reached node
// out_valid is registered from the S_WALK step, or from S_MARK for a search
// after reset the child table and end marks are swept one entry a cycle,
//   MAX_NODES*ALPHABET_SIZE entries (26624 by default), with busy high
// nodes are only returned to the pool by reset
module trie_insert_search_prefix
  import tisp_pkg::*;
#(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_last_letter,
  output logic                out_valid,
  output logic                out_found,
  output logic                out_pool_full
);

  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int FREE_W      = NODE_W + 1;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int ADDR_W      = $clog2(CHILD_DEPTH);
  localparam int SYM_W       = $clog2(ALPHABET_SIZE);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_WALK, S_MARK} state_t;

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   cur_node_r, cur_node_nxt;
  logic                pm_r, pm_nxt;
  logic                ovf_r, ovf_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic                last_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_pool_full_r, out_pool_full_nxt;

  logic [SYM_W-1:0]    sym_sat;
  logic [ADDR_W-1:0]   acc_addr;
  logic                accept;

  tisp_mem_req_t       mem_req;
  logic [NODE_W-1:0]   child_q;
  logic                mark_q;
  logic [NODE_W-1:0]   mark_addr;
  logic                store_ready;

  logic [NODE_W-1:0]   walk_node;
  logic                walk_pm;
  logic                walk_ovf;
  logic [FREE_W-1:0]   walk_free;
  logic                walk_alloc;
  logic                walk_alive;

  tisp_store #(
    .MAX_NODES    (MAX_NODES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (mem_req),
    .child_raddr(acc_addr),
    .child_waddr(addr_r),
    .child_wdata(free_r[NODE_W-1:0]),
    .mark_addr  (mark_addr),
    .child_q    (child_q),
    .mark_q     (mark_q),
    .ready      (store_ready)
  );

  assign accept = start && (state_r == S_IDLE);

  // letters past the alphabet fold onto its last letter
  assign sym_sat = (9'(in_letter) >= 9'(ALPHABET_SIZE)) ? SYM_W'(ALPHABET_SIZE - 1)
                                                        : SYM_W'(in_letter);
  assign acc_addr = ADDR_W'(cur_node_r) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(sym_sat);

  // one trie step on the child entry read back from the store
  always_comb begin
    walk_node  = cur_node_r;
    walk_pm    = pm_r;
    walk_ovf   = ovf_r;
    walk_free  = free_r;
    walk_alloc = 1'b0;
    if (!pm_r && !ovf_r) begin
      priority if (child_q != '0) begin
        walk_node = child_q;
      end else if (cmd_r == CMD_INSERT) begin
        if (free_r < FREE_W'(MAX_NODES)) begin
          walk_alloc = 1'b1;
          walk_node  = free_r[NODE_W-1:0];
          walk_free  = free_r + 1'b1;
        end else begin
          walk_ovf = 1'b1;
        end
      end else begin
        walk_pm = 1'b1;
      end
    end
    walk_alive = !walk_pm && !walk_ovf;
  end

  always_comb begin
    state_nxt         = state_r;
    cur_node_nxt      = cur_node_r;
    pm_nxt            = pm_r;
    ovf_nxt           = ovf_r;
    free_nxt          = free_r;
    out_valid_nxt     = 1'b0;
    out_found_nxt     = out_found_r;
    out_pool_full_nxt = out_pool_full_r;
    mem_req           = '0;
    mark_addr         = walk_node;
    unique case (state_r)
      S_INIT: begin
        if (store_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mem_req.child_re = 1'b1;
          state_nxt        = S_WALK;
        end
      end
      S_WALK: begin
        cur_node_nxt     = walk_node;
        pm_nxt           = walk_pm;
        ovf_nxt          = walk_ovf;
        free_nxt         = walk_free;
        mem_req.child_we = walk_alloc;
        state_nxt        = S_IDLE;
        if (last_r) begin
          priority if (cmd_r == CMD_SEARCH) begin
            mem_req.mark_re = 1'b1;
            state_nxt       = S_MARK;
          end else begin
            mem_req.mark_we   = (cmd_r == CMD_INSERT) && walk_alive;
            out_valid_nxt     = 1'b1;
            out_found_nxt     = walk_alive;
            out_pool_full_nxt = walk_ovf;
            cur_node_nxt      = '0;
            pm_nxt            = 1'b0;
            ovf_nxt           = 1'b0;
          end
        end
      end
      S_MARK: begin
        out_valid_nxt     = 1'b1;
        out_found_nxt     = !pm_r && !ovf_r && mark_q;
        out_pool_full_nxt = ovf_r;
        cur_node_nxt      = '0;
        pm_nxt            = 1'b0;
        ovf_nxt           = 1'b0;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_node_r  <= '0;
      pm_r        <= 1'b0;
      ovf_r       <= 1'b0;
      free_r      <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cur_node_r      <= cur_node_nxt;
      pm_r            <= pm_nxt;
      ovf_r           <= ovf_nxt;
      free_r          <= free_nxt;
      out_valid_r     <= out_valid_nxt;
      out_found_r     <= out_found_nxt;
      out_pool_full_r <= out_pool_full_nxt;
      if (accept) begin
        cmd_r  <= in_command;
        last_r <= in_last_letter;
        addr_r <= acc_addr;
      end
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_pool_full = out_pool_full_r;

  `TISP_ASSERT(a_no_request_while_clearing, clk, rst_n, !store_ready |-> busy, "request taken during clear")
  `TISP_ASSERT(a_alloc_inside_pool, clk, rst_n, mem_req.child_we |-> (free_r < FREE_W'(MAX_NODES)) && (free_r != '0), "allocation outside pool")
  `TISP_ASSERT(a_alloc_advances_free, clk, rst_n, mem_req.child_we |=> free_r == $past(free_r) + 1'b1, "free counter did not advance")
  `TISP_ASSERT(a_result_after_step, clk, rst_n, out_valid |-> ($past(state_r) == S_WALK || $past(state_r) == S_MARK), "result without a step")
  `TISP_ASSERT(a_word_restarts_at_root, clk, rst_n, out_valid |-> (cur_node_r == '0) && !pm_r && !ovf_r, "word state not cleared after result")
  `TISP_ASSERT_ALWAYS(a_quiet_after_reset, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

// ----- test/trie_lookup_checker.sv -----
`timescale 1ns / 1ps

module trie_lookup_checker
  import tisp_pkg::*;
#(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_last_letter,
  input  logic                out_valid,
  input  logic                out_found,
  input  logic                out_pool_full,
  output int                  mismatches,
  output int                  outstanding
);

  typedef struct packed {
    logic found;
    logic pool_full;
  } lookup_t;

  int unsigned child_of [MAX_NODES*ALPHABET_SIZE];
  bit          word_end [MAX_NODES];
  int unsigned walk_node;
  int unsigned free_node;
  bit          walk_lost;
  bit          walk_overflow;
  lookup_t     awaited [$];
  lookup_t     want;
  int          mismatch_cnt = 0;

  assign mismatches = mismatch_cnt;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // one letter of a word: walk, allocate, and on the last letter queue the verdict
  task automatic walk_letter(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter,
                             input logic last);
    int unsigned sym;
    int unsigned slot;
    int unsigned child;
    bit          live;
    lookup_t     verdict;
    sym = 32'(letter);
    if (sym >= ALPHABET_SIZE) begin
      sym = ALPHABET_SIZE - 1;
    end
    if (!walk_lost && !walk_overflow) begin
      slot  = walk_node * ALPHABET_SIZE + sym;
      child = child_of[slot];
      if (child != 0) begin
        walk_node = child;
      end else if (cmd == CMD_INSERT) begin
        if (free_node < MAX_NODES) begin
          child_of[slot] = free_node;
          walk_node      = free_node;
          free_node++;
        end else begin
          walk_overflow = 1'b1;
        end
      end else begin
        walk_lost = 1'b1;
      end
    end
    if (last) begin
      live = !walk_lost && !walk_overflow;
      if (cmd == CMD_INSERT) begin
        if (live) begin
          word_end[walk_node] = 1'b1;
        end
        verdict.found = live;
      end else if (cmd == CMD_SEARCH) begin
        verdict.found = live && word_end[walk_node];
      end else begin
        // prefix test, and the fourth code, not named in the package, behaves the same
        verdict.found = live;
      end
      verdict.pool_full = walk_overflow;
      awaited.push_back(verdict);
      walk_node     = 0;
      walk_lost     = 1'b0;
      walk_overflow = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (child_of[i]) child_of[i] = 0;
      foreach (word_end[i]) word_end[i] = 1'b0;
      walk_node     = 0;
      free_node     = 1;
      walk_lost     = 1'b0;
      walk_overflow = 1'b0;
      awaited.delete();
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (awaited.size() == 0) begin
          report($sformatf("result found=%0b pool_full=%0b with no request pending",
                           out_found, out_pool_full));
        end else begin
          want = awaited.pop_front();
          if (out_found !== want.found) begin
            report($sformatf("found %0b, wanted %0b", out_found, want.found));
          end
          if (out_pool_full !== want.pool_full) begin
            report($sformatf("pool_full %0b, wanted %0b", out_pool_full, want.pool_full));
          end
        end
      end
      if (start && !busy) begin
        walk_letter(in_command, in_letter, in_last_letter);
      end
      outstanding <= awaited.size();
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tisp_pkg::*;

  // the fourth command code, which the block treats as a prefix test
  localparam logic [CMD_W-1:0] CMD_ALT_PREFIX = 2'd3;
  localparam int MAX_LEN      = 8;
  localparam int BANK_SIZE    = 16;
  localparam int ALPHABET_TOP = 25;

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [CMD_W-1:0]    in_command     = CMD_INSERT;
  logic [LETTER_W-1:0] in_letter      = '0;
  logic                in_last_letter = 1'b0;
  logic                busy;
  logic                out_valid;
  logic                out_found;
  logic                out_pool_full;
  int                  mismatches;
  int                  outstanding;

  logic [LETTER_W-1:0] word_buf [MAX_LEN];
  logic [LETTER_W-1:0] bank [BANK_SIZE][MAX_LEN];
  int                  bank_len [BANK_SIZE];
  int                  bank_fill = 0;
  int                  bank_next = 0;
  int                  letters_sent = 0;
  int                  idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  trie_insert_search_prefix u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_letter      (in_letter),
    .in_last_letter (in_last_letter),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_pool_full  (out_pool_full)
  );

  trie_lookup_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_letter      (in_letter),
    .in_last_letter (in_last_letter),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_pool_full  (out_pool_full),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // called at a rising edge; returns at the edge that takes the request, or after an idle gap with start low
  task automatic send_letter(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter,
                             input logic last);
    in_command     <= cmd;
    in_letter      <= letter;
    in_last_letter <= last;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    letters_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic make_word(input int len, input int top_letter);
    for (int i = 0; i < len; i++) begin
      word_buf[i] = LETTER_W'($urandom_range(0, top_letter));
      // now and then a letter past z, which saturates
      if ($urandom_range(0, 19) == 0) begin
        word_buf[i] = LETTER_W'($urandom_range(ALPHABET_TOP + 1, 31));
      end
    end
  endtask

  task automatic bank_word(input int len);
    for (int i = 0; i < len; i++) bank[bank_next][i] = word_buf[i];
    bank_len[bank_next] = len;
    bank_next = (bank_next + 1) % BANK_SIZE;
    if (bank_fill < BANK_SIZE) begin
      bank_fill++;
    end
  endtask

  task automatic recall_word(output int len);
    int k;
    k   = $urandom_range(0, bank_fill - 1);
    len = bank_len[k];
    for (int i = 0; i < len; i++) word_buf[i] = bank[k][i];
  endtask

  // mixed words switch command on some letters; the last letter's command rules
  task automatic send_word(input logic [CMD_W-1:0] cmd, input int len, input bit mixed);
    logic [CMD_W-1:0] c;
    for (int i = 0; i < len; i++) begin
      c = cmd;
      if (mixed && $urandom_range(0, 2) == 0) begin
        c = CMD_W'($urandom_range(0, 3));
      end
      send_letter(c, word_buf[i], i == len - 1);
    end
  endtask

  function automatic logic [CMD_W-1:0] lookup_cmd();
    case ($urandom_range(0, 3))
      0, 1:    return CMD_SEARCH;
      2:       return CMD_PREFIX;
      default: return CMD_ALT_PREFIX;
    endcase
  endfunction

  // one random word: new inserts, or lookups of fresh words, stored words and their prefixes
  task automatic random_word(input int insert_pct, input int min_len, input int max_len,
                             input int top_letter);
    int len;
    bit mixed;
    mixed = ($urandom_range(0, 9) == 0);
    if (bank_fill == 0 || $urandom_range(0, 99) < insert_pct) begin
      len = $urandom_range(min_len, max_len);
      make_word(len, top_letter);
      bank_word(len);
      send_word(CMD_INSERT, len, mixed);
    end else if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(min_len, max_len);
      make_word(len, top_letter);
      send_word(lookup_cmd(), len, mixed);
    end else begin
      recall_word(len);
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(1, len);
      end
      send_word(lookup_cmd(), len, mixed);
    end
  endtask

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words; the block sweeps its tables first with busy high
    idle_pct = 30;
    send_letter(CMD_INSERT, 5'd0, 1'b1);
    send_letter(CMD_SEARCH, 5'd0, 1'b1);
    send_letter(CMD_PREFIX, 5'd0, 1'b1);
    send_letter(CMD_SEARCH, 5'd1, 1'b1);
    send_letter(CMD_INSERT, 5'd25, 1'b0);
    send_letter(CMD_INSERT, 5'd25, 1'b1);
    // letters past z land on z
    send_letter(CMD_SEARCH, 5'd31, 1'b0);
    send_letter(CMD_SEARCH, 5'd26, 1'b1);
    send_letter(CMD_ALT_PREFIX, 5'd25, 1'b1);
    send_letter(CMD_SEARCH, 5'd25, 1'b1);
    // command switches mid word: result follows the last letter
    send_letter(CMD_INSERT, 5'd3, 1'b0);
    send_letter(CMD_SEARCH, 5'd3, 1'b1);
    // missing path stops the walk for the rest of the word
    send_letter(CMD_SEARCH, 5'd1, 1'b0);
    send_letter(CMD_SEARCH, 5'd0, 1'b1);
    for (int i = 0; i < MAX_LEN; i++) begin
      send_letter(CMD_INSERT, LETTER_W'(i), i == MAX_LEN - 1);
    end
    send_letter(CMD_PREFIX, 5'd0, 1'b0);
    send_letter(CMD_PREFIX, 5'd1, 1'b0);
    send_letter(CMD_PREFIX, 5'd2, 1'b1);

    // dense words over a few letters, so lookups hit often
    while (letters_sent < 525) begin
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      random_word(40, 1, 5, 3);
    end

    // long words over the whole alphabet drain the node pool
    while (letters_sent < 1700) begin
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      random_word(95, 6, MAX_LEN, ALPHABET_TOP);
    end

    // pool exhausted, back to back requests
    idle_pct = 0;
    while (letters_sent < 1850) begin
      random_word(50, 1, MAX_LEN, ALPHABET_TOP);
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
